/* rtl/separable_gaussian_blur_5x5_assert.svh */
`ifndef SEPARABLE_GAUSSIAN_BLUR_5X5_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_5X5_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SGB_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SGB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sgb_pkg.sv */
`default_nettype none

package sgb_pkg;

    localparam int unsigned PIX_W          = 16;
    localparam int unsigned COEF_W         = 8;
    localparam int unsigned DIM_W          = 12;
    localparam int unsigned OUT_COORD_W    = 11;
    localparam int unsigned NUM_LINES      = 4;
    localparam int unsigned LINE_SEL_W     = 2;
    localparam int unsigned NUM_TAPS       = 5;
    localparam int unsigned TAP_SPAN       = 4;
    localparam int unsigned CENTER_OFS     = 2;
    localparam int unsigned MIN_DIM        = 5;
    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    localparam logic [COEF_W-1:0] RST_COEF_OUTER  = 8'd1;
    localparam logic [COEF_W-1:0] RST_COEF_INNER  = 8'd4;
    localparam logic [COEF_W-1:0] RST_COEF_CENTER = 8'd7;
    localparam logic [DIM_W-1:0]  RST_FRAME_DIM   = 12'd2048;

    // Filter datapath widths: pre-add, product, accumulated sum.
    localparam int unsigned PSUM_W = PIX_W + 1;
    localparam int unsigned PROD_W = PSUM_W + COEF_W;
    localparam int unsigned SUM_W  = PROD_W + 2;

    // Division by 17 as multiplication by ceil(2^32 / 17), exact for sums below 2^27.
    localparam int unsigned              RECIP_W     = 28;
    localparam int unsigned              RECIP_SHIFT = 32;
    localparam int unsigned              SCALED_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0]       RECIP_MUL   = 28'd252645136;

    // Register stages inside one filter unit.
    localparam int unsigned TAP_LAT = 4;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_OUTER  = 3'd0,
        REG_COEF_INNER  = 3'd1,
        REG_COEF_CENTER = 3'd2,
        REG_FRAME_WIDTH = 3'd3,
        REG_FRAME_HEIGHT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]       blurred;
        logic [OUT_COORD_W-1:0] row;
        logic [OUT_COORD_W-1:0] col;
        logic                   last;
    } t_result;

endpackage

`default_nettype wire

/* rtl/sgb_tap5.sv */
`default_nettype none

module sgb_tap5 (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [sgb_pkg::NUM_TAPS-1:0][sgb_pkg::PIX_W-1:0] i_taps,
    input  logic [sgb_pkg::COEF_W-1:0]                    i_coef_outer,
    input  logic [sgb_pkg::COEF_W-1:0]                    i_coef_inner,
    input  logic [sgb_pkg::COEF_W-1:0]                    i_coef_center,
    output logic [sgb_pkg::PIX_W-1:0]                     o_result
);
    import sgb_pkg::*;

    logic [PSUM_W-1:0]   r_outer_sum;
    logic [PSUM_W-1:0]   r_inner_sum;
    logic [PIX_W-1:0]    r_center;
    logic [PROD_W-1:0]   r_prod_outer;
    logic [PROD_W-1:0]   r_prod_inner;
    logic [PROD_W-1:0]   r_prod_center;
    logic [SUM_W-1:0]    r_sum;
    logic [SCALED_W-1:0] r_scaled;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_outer_sum   <= PSUM_W'(i_taps[0]) + PSUM_W'(i_taps[4]);
            r_inner_sum   <= PSUM_W'(i_taps[1]) + PSUM_W'(i_taps[3]);
            r_center      <= i_taps[2];
            r_prod_outer  <= PROD_W'(r_outer_sum) * PROD_W'(i_coef_outer);
            r_prod_inner  <= PROD_W'(r_inner_sum) * PROD_W'(i_coef_inner);
            r_prod_center <= PROD_W'(r_center) * PROD_W'(i_coef_center);
            r_sum         <= SUM_W'(r_prod_outer) + SUM_W'(r_prod_inner)
                             + SUM_W'(r_prod_center);
            r_scaled      <= SCALED_W'(r_sum) * SCALED_W'(RECIP_MUL);
        end
    end

    assign o_result = r_scaled[RECIP_SHIFT +: PIX_W];

endmodule

`default_nettype wire

/* rtl/sgb_line_store.sv */
`default_nettype none

module sgb_line_store #(
    parameter int unsigned MAX_WIDTH = sgb_pkg::DEF_MAX_WIDTH
) (
    input  logic                                           i_clk,
    input  logic                                           i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]                   i_rd_addr,
    output logic [sgb_pkg::NUM_LINES-1:0][sgb_pkg::PIX_W-1:0] o_rd_data,
    input  logic                                           i_wr_en,
    input  logic [sgb_pkg::LINE_SEL_W-1:0]                 i_wr_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0]                   i_wr_addr,
    input  logic [sgb_pkg::PIX_W-1:0]                      i_wr_data
);
    import sgb_pkg::*;

    for (genvar b = 0; b < NUM_LINES; b++) begin : g_bank
        logic [PIX_W-1:0] r_mem [MAX_WIDTH];
        logic [PIX_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_bank == LINE_SEL_W'(b))) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= r_mem[i_rd_addr];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

`default_nettype wire

/* rtl/separable_gaussian_blur_5x5.sv */
//  Channel   Direction  Handshake                 Word
//  pixel     in         i_in_valid / o_in_stall   i_pixel
//  result    out        o_out_valid / i_out_stall o_blurred, o_out_row, o_out_col, o_frame_last
//  config    in         APB (psel, penable)       pwdata / prdata, five registers
//
//  One pixel is accepted per clock while o_in_stall is low.
//  Both filters are four-stage pipelines and each line bank reads and writes at most once a clock.
//  Reset loads the default registers and clears counters, row window and valid bits.
//  The line stores are not cleared; every entry is written before a result uses it.
//  An output register and a one-word skid stage absorb a stall; input stalls only while
//  the skid stage is full.
`default_nettype none

`include "separable_gaussian_blur_5x5_assert.svh"

module separable_gaussian_blur_5x5 #(
    parameter int unsigned MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = sgb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sgb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sgb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sgb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sgb_pkg::PIX_W-1:0]         i_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sgb_pkg::PIX_W-1:0]         o_blurred,
    output logic [sgb_pkg::OUT_COORD_W-1:0]   o_out_row,
    output logic [sgb_pkg::OUT_COORD_W-1:0]   o_out_col,
    output logic                              o_frame_last
);
    import sgb_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);
    localparam int unsigned WDW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int unsigned HDW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
    localparam int unsigned PIPE_DEPTH = 2 * TAP_LAT;
    localparam int unsigned RD_STAGE   = TAP_LAT - 2;
    localparam int unsigned WR_STAGE   = TAP_LAT - 1;
    localparam int unsigned OUT_STAGE  = PIPE_DEPTH - 1;

    typedef struct packed {
        logic                   valid;
        logic                   emit;
        logic                   last;
        logic [LINE_SEL_W-1:0]  slot;
        logic [CW-1:0]          col;
        logic [OUT_COORD_W-1:0] row;
    } t_stage;

    logic [COEF_W-1:0] r_coef_outer;
    logic [COEF_W-1:0] r_coef_inner;
    logic [COEF_W-1:0] r_coef_center;
    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;

    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    logic [PIX_W-1:0]  r_win [TAP_SPAN];
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;

    logic [WDW-1:0]    fw_ext;
    logic [WDW-1:0]    w_lim;
    logic [WDW-1:0]    col_ext;
    logic [HDW-1:0]    fh_ext;
    logic [HDW-1:0]    h_lim;
    logic [HDW-1:0]    row_ext;
    logic              wrap_col;
    logic              wrap_row;
    logic              col_ok;
    logic              row_ok;

    logic              adv;
    logic              in_acc;
    t_stage            n_stage;
    t_stage            r_ctrl [PIPE_DEPTH];

    logic [NUM_TAPS-1:0][PIX_W-1:0]  h_taps;
    logic [NUM_TAPS-1:0][PIX_W-1:0]  v_taps;
    logic [PIX_W-1:0]                h_res;
    logic [PIX_W-1:0]                v_res;
    logic [NUM_LINES-1:0][PIX_W-1:0] line_rd;
    logic [LINE_SEL_W-1:0]           v_slot;

    logic              push;
    logic              take;
    t_result           push_res;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;
    logic              n_out_valid;
    t_result           n_out;
    logic              n_skid_valid;
    t_result           n_skid;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_outer   <= RST_COEF_OUTER;
            r_coef_inner   <= RST_COEF_INNER;
            r_coef_center  <= RST_COEF_CENTER;
            r_frame_width  <= RST_FRAME_DIM;
            r_frame_height <= RST_FRAME_DIM;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COEF_OUTER:   r_coef_outer   <= pwdata[COEF_W-1:0];
                REG_COEF_INNER:   r_coef_inner   <= pwdata[COEF_W-1:0];
                REG_COEF_CENTER:  r_coef_center  <= pwdata[COEF_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_COEF_OUTER:   prdata = APB_DATA_W'(r_coef_outer);
            REG_COEF_INNER:   prdata = APB_DATA_W'(r_coef_inner);
            REG_COEF_CENTER:  prdata = APB_DATA_W'(r_coef_center);
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Frame geometry, saturated to the supported range.
    always_comb begin
        fw_ext  = WDW'(r_frame_width);
        fh_ext  = HDW'(r_frame_height);
        w_lim   = (fw_ext < WDW'(MIN_DIM)) ? WDW'(MIN_DIM) :
                  (fw_ext > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : fw_ext;
        h_lim   = (fh_ext < HDW'(MIN_DIM)) ? HDW'(MIN_DIM) :
                  (fh_ext > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : fh_ext;
        col_ext = WDW'(r_col);
        row_ext = HDW'(r_row);
        wrap_col = (col_ext + WDW'(1)) >= w_lim;
        wrap_row = (row_ext + HDW'(1)) >= h_lim;
        col_ok  = (col_ext >= WDW'(TAP_SPAN)) && (col_ext < w_lim);
        row_ok  = (row_ext >= HDW'(TAP_SPAN)) && (row_ext < h_lim);
        n_col   = wrap_col ? '0 : r_col + CW'(1);
        n_row   = wrap_col ? (wrap_row ? '0 : r_row + RW'(1)) : r_row;
    end

    assign adv        = !r_skid_valid;
    assign in_acc     = i_in_valid && adv;
    assign o_in_stall = !adv;

    always_comb begin
        n_stage.valid = in_acc && col_ok;
        n_stage.emit  = row_ok;
        n_stage.last  = (row_ext == h_lim - HDW'(1)) && (col_ext == w_lim - WDW'(1));
        n_stage.slot  = r_row[LINE_SEL_W-1:0];
        n_stage.col   = r_col - CW'(CENTER_OFS);
        n_stage.row   = OUT_COORD_W'(r_row - RW'(CENTER_OFS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int k = 0; k < TAP_SPAN; k++) begin
                r_win[k] <= '0;
            end
        end else if (in_acc) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_win[0] <= i_pixel;
            for (int k = 1; k < TAP_SPAN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_ctrl[k] <= '0;
            end
        end else if (adv) begin
            r_ctrl[0] <= n_stage;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_ctrl[k] <= r_ctrl[k-1];
            end
        end
    end

    // Horizontal pass.
    always_comb begin
        h_taps[0] = i_pixel;
        for (int k = 1; k < NUM_TAPS; k++) begin
            h_taps[k] = r_win[k-1];
        end
    end

    sgb_tap5 u_hfilt (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_taps        (h_taps),
        .i_coef_outer  (r_coef_outer),
        .i_coef_inner  (r_coef_inner),
        .i_coef_center (r_coef_center),
        .o_result      (h_res)
    );

    sgb_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (r_ctrl[RD_STAGE].col),
        .o_rd_data (line_rd),
        .i_wr_en   (adv && r_ctrl[WR_STAGE].valid),
        .i_wr_bank (r_ctrl[WR_STAGE].slot),
        .i_wr_addr (r_ctrl[WR_STAGE].col),
        .i_wr_data (h_res)
    );

    // Vertical pass: the oldest line sits in the bank that this row overwrites.
    assign v_slot = r_ctrl[WR_STAGE].slot;

    always_comb begin
        v_taps[0] = h_res;
        v_taps[1] = line_rd[v_slot - LINE_SEL_W'(1)];
        v_taps[2] = line_rd[v_slot - LINE_SEL_W'(2)];
        v_taps[3] = line_rd[v_slot - LINE_SEL_W'(3)];
        v_taps[4] = line_rd[v_slot];
    end

    sgb_tap5 u_vfilt (
        .i_clk         (i_clk),
        .i_en          (adv),
        .i_taps        (v_taps),
        .i_coef_outer  (r_coef_outer),
        .i_coef_inner  (r_coef_inner),
        .i_coef_center (r_coef_center),
        .o_result      (v_res)
    );

    // Output register with skid stage.
    assign push = adv && r_ctrl[OUT_STAGE].valid && r_ctrl[OUT_STAGE].emit;
    assign take = r_out_valid && !i_out_stall;

    always_comb begin
        push_res.blurred = v_res;
        push_res.row     = r_ctrl[OUT_STAGE].row;
        push_res.col     = OUT_COORD_W'(r_ctrl[OUT_STAGE].col);
        push_res.last    = r_ctrl[OUT_STAGE].last;

        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                n_out       = push_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = push_res;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            r_out        <= n_out;
            r_skid       <= n_skid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_blurred    = r_out.blurred;
    assign o_out_row    = r_out.row;
    assign o_out_col    = r_out.col;
    assign o_frame_last = r_out.last;

    `SGB_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n,
        r_skid_valid, r_out_valid, "skid word held without an output word")
    `SGB_ASSERT_NEXT(a_push_to_skid, i_clk, i_rst_n,
        push && r_out_valid && i_out_stall, r_skid_valid,
        "result arriving at a stalled output was not kept in the skid stage")
    `SGB_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n,
        r_skid_valid && !i_out_stall, !r_skid_valid && r_out_valid,
        "skid word not moved to the output register when taken")

endmodule

`default_nettype wire

/* dv/tb_separable_gaussian_blur_5x5.sv */
module tb_separable_gaussian_blur_5x5;
    import sgb_pkg::*;

    localparam int unsigned DIVISOR     = 17;
    localparam int unsigned REG_COUNT   = 5;
    localparam int unsigned SETTLE_CYC  = 16;
    localparam int unsigned HOLD_CYC    = 400;
    localparam int unsigned IDLE_PCT    = 23;
    localparam int unsigned RAND_PIXELS = 950;
    localparam int unsigned MAX_REPORTS = 50;
    localparam int unsigned TIMEOUT     = 4000000;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr        = '0;
    logic [APB_DATA_W-1:0]  pwdata       = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_stall;
    logic [PIX_W-1:0]       i_pixel      = '0;
    logic                   o_out_valid;
    logic                   i_out_stall  = 1'b0;
    logic [PIX_W-1:0]       o_blurred;
    logic [OUT_COORD_W-1:0] o_out_row;
    logic [OUT_COORD_W-1:0] o_out_col;
    logic                   o_frame_last;

    separable_gaussian_blur_5x5 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel      (i_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_blurred    (o_blurred),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last)
    );

    class blur_tracker;
        int unsigned      k_outer;
        int unsigned      k_inner;
        int unsigned      k_center;
        int unsigned      width_reg;
        int unsigned      height_reg;
        logic [PIX_W-1:0] recent[TAP_SPAN];
        logic [PIX_W-1:0] row_lines[NUM_LINES*DEF_MAX_WIDTH];
        int unsigned      col_pos;
        int unsigned      row_pos;
        t_result          pending_blurs[$];
        int unsigned      errors;

        function new();
            k_outer    = 32'(RST_COEF_OUTER);
            k_inner    = 32'(RST_COEF_INNER);
            k_center   = 32'(RST_COEF_CENTER);
            width_reg  = 32'(RST_FRAME_DIM);
            height_reg = 32'(RST_FRAME_DIM);
            foreach (recent[i]) recent[i] = '0;
            foreach (row_lines[i]) row_lines[i] = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        function int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
            if (v < MIN_DIM) return MIN_DIM;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned eff_width();
            return clamp_dim(width_reg, DEF_MAX_WIDTH);
        endfunction

        function int unsigned eff_height();
            return clamp_dim(height_reg, DEF_MAX_HEIGHT);
        endfunction

        function logic [PIX_W-1:0] tap5(input int unsigned a0, input int unsigned a1,
                                        input int unsigned a2, input int unsigned a3,
                                        input int unsigned a4);
            int unsigned s;
            s = (a0 + a4) * k_outer + (a1 + a3) * k_inner + a2 * k_center;
            return PIX_W'(s / DIVISOR);
        endfunction

        function void write_reg(input logic [REG_IDX_W-1:0] idx,
                                input logic [APB_DATA_W-1:0] v);
            case (idx)
                REG_COEF_OUTER:   k_outer    = 32'(v[COEF_W-1:0]);
                REG_COEF_INNER:   k_inner    = 32'(v[COEF_W-1:0]);
                REG_COEF_CENTER:  k_center   = 32'(v[COEF_W-1:0]);
                REG_FRAME_WIDTH:  width_reg  = 32'(v[DIM_W-1:0]);
                REG_FRAME_HEIGHT: height_reg = 32'(v[DIM_W-1:0]);
                default: ;
            endcase
        endfunction

        function void take_pixel(input logic [PIX_W-1:0] p);
            int unsigned      w, h, r, c, mc, slot;
            int unsigned      v1, v2, v3, v4;
            logic [PIX_W-1:0] m;
            t_result          res;
            w = eff_width();
            h = eff_height();
            r = row_pos;
            c = col_pos;
            if (c >= TAP_SPAN && c < w) begin
                mc   = c - CENTER_OFS;
                m    = tap5(32'(p), 32'(recent[0]), 32'(recent[1]), 32'(recent[2]),
                            32'(recent[3]));
                slot = (r % NUM_LINES) * DEF_MAX_WIDTH + mc;
                if (r >= TAP_SPAN && r < h) begin
                    v1 = 32'(row_lines[((r - 1) % NUM_LINES) * DEF_MAX_WIDTH + mc]);
                    v2 = 32'(row_lines[((r - 2) % NUM_LINES) * DEF_MAX_WIDTH + mc]);
                    v3 = 32'(row_lines[((r - 3) % NUM_LINES) * DEF_MAX_WIDTH + mc]);
                    v4 = 32'(row_lines[slot]);
                    res.blurred = tap5(32'(m), v1, v2, v3, v4);
                    res.row     = OUT_COORD_W'(r - CENTER_OFS);
                    res.col     = OUT_COORD_W'(mc);
                    res.last    = (r == h - 1) && (c == w - 1);
                    pending_blurs.push_back(res);
                end
                row_lines[slot] = m;
            end
            recent[3] = recent[2];
            recent[2] = recent[1];
            recent[1] = recent[0];
            recent[0] = p;
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void match_result(input logic [PIX_W-1:0] blurred,
                                   input logic [OUT_COORD_W-1:0] row,
                                   input logic [OUT_COORD_W-1:0] col,
                                   input logic last);
            t_result want;
            if (pending_blurs.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected word blurred=%0d row=%0d col=%0d last=%0b",
                             $time, blurred, row, col, last);
                errors++;
                return;
            end
            want = pending_blurs.pop_front();
            if (blurred !== want.blurred || row !== want.row || col !== want.col ||
                last !== want.last) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: expected %0d/%0d/%0d/%0b, actual %0d/%0d/%0d/%0b",
                             $time, want.blurred, want.row, want.col, want.last,
                             blurred, row, col, last);
                errors++;
            end
        endfunction
    endclass

    blur_tracker tracker;
    int unsigned hold_kick = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic        in_gaps   = 1'b1;
    logic        out_gaps  = 1'b1;

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0)
                tracker.match_result(o_blurred, o_out_row, o_out_col, o_frame_last);
            if (hold_kick != hold_seen) begin
                hold_seen = hold_kick;
                hold_left = HOLD_CYC;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= out_gaps && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] p);
        if (in_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_pixel    <= p;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.take_pixel(p);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        if (sel < 20) return '1;
        if (sel < 30) return PIX_W'($urandom_range(255));
        return PIX_W'($urandom);
    endfunction

    function automatic logic [APB_DATA_W-1:0] pick_coef();
        logic [APB_DATA_W-1:0] v;
        int unsigned           sel;
        v   = $urandom;
        sel = $urandom_range(9);
        if (sel == 0) v[COEF_W-1:0] = '0;
        else if (sel == 1) v[COEF_W-1:0] = '1;
        return v;
    endfunction

    function automatic logic [APB_DATA_W-1:0] pick_dim(input int unsigned top);
        logic [APB_DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(6) == 0) v[DIM_W-1:0] = DIM_W'($urandom_range(MIN_DIM - 1));
        else v[DIM_W-1:0] = DIM_W'($urandom_range(top, MIN_DIM));
        return v;
    endfunction

    task automatic feed_pixels(input int unsigned n);
        repeat (n) push_pixel(pick_pixel());
        i_in_valid <= 1'b0;
    endtask

    task automatic settle();
        while (tracker.pending_blurs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin
        int unsigned fed;
        int unsigned phase;
        int unsigned frames;
        int unsigned n;
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One small frame at the reset coefficients, with full-scale pixels and a
        // single dark one at the center.
        set_reg(REG_FRAME_WIDTH, 32'd5);
        set_reg(REG_FRAME_HEIGHT, 32'd5);
        for (int i = 0; i < 25; i++) push_pixel((i == 12) ? 16'h0000 : 16'hFFFF);
        i_in_valid <= 1'b0;
        settle();

        // Writes past the register list must leave every register untouched.
        for (int k = 0; k < 3; k++) set_reg(REG_IDX_W'(REG_COUNT + k), $urandom);

        fed   = 0;
        phase = 0;
        while (fed < RAND_PIXELS) begin
            settle();
            in_gaps = (phase % 6 != 3);
            out_gaps <= (phase % 6 != 3);
            set_reg(REG_COEF_OUTER, pick_coef());
            set_reg(REG_COEF_INNER, pick_coef());
            set_reg(REG_COEF_CENTER, pick_coef());
            if (phase == 2) begin
                set_reg(REG_FRAME_WIDTH, 32'd12);
                set_reg(REG_FRAME_HEIGHT, 32'd12);
                hold_kick <= hold_kick + 1;
            end else begin
                set_reg(REG_FRAME_WIDTH, pick_dim(12));
                set_reg(REG_FRAME_HEIGHT, pick_dim(9));
            end
            frames = $urandom_range(2, 1);
            n = frames * tracker.eff_width() * tracker.eff_height();
            feed_pixels(n);
            fed += n;
            phase++;
        end

        // A tall frame cut short: the height drops below the current row, so that
        // row is dropped and a new frame starts after it.
        settle();
        in_gaps = 1'b1;
        out_gaps <= 1'b1;
        set_reg(REG_FRAME_WIDTH, 32'd5);
        set_reg(REG_FRAME_HEIGHT, 32'h0000_0FFF);
        feed_pixels(tracker.eff_width() * 40);
        settle();
        set_reg(REG_FRAME_HEIGHT, 32'd0);
        feed_pixels(tracker.eff_width() * (1 + tracker.eff_height()));

        while (tracker.pending_blurs.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYC) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sgb_pkg.sv
rtl/sgb_tap5.sv
rtl/sgb_line_store.sv
rtl/separable_gaussian_blur_5x5.sv
dv/tb_separable_gaussian_blur_5x5.sv
